// ----- rtl/epoch_seconds_to_calendar_macros.svh -----
// ----------------------------------------------------------------------------
// epoch seconds to calendar: assertion macros
// concurrent checks on aclk, switched off for synthesis
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

`ifndef SYNTHESIS
`define ESC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define ESC_ASSERT_NORST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define ESC_ASSERT(lbl, prop, msg)
`define ESC_ASSERT_NORST(lbl, prop, msg)
`endif

`endif

// ----- rtl/esc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// constants and month table for the epoch seconds to calendar pipeline
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int NUM_STAGES = 8;

    typedef logic [3:0] month_idx_t;
    typedef logic [8:0] doy_t;

    // reciprocals, exact for the operand ranges used
    localparam logic [25:0] DAY_RECIP        = 26'd50903317; // 2^35 / 675, rounded up
    localparam logic [13:0] HOUR_RECIP       = 14'd9321;     // 2^21 / 225, rounded up
    localparam logic [10:0] MIN_RECIP        = 11'd1093;     // 2^14 / 15, rounded up
    localparam logic [16:0] QUAD_RECIP       = 17'd91868;    // 2^27 / 1461, rounded up

    localparam logic [16:0] SECS_PER_DAY     = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR    = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN     = 6'd60;
    localparam logic [10:0] DAYS_PER_QUAD    = 11'd1461;

    // days counted from 1968-01-01, start of a leap cycle
    localparam logic [15:0] EPOCH_DAY_OFFSET = 16'd731;
    // days from 1970 to 2100-03-01, skip the missing feb 29
    localparam logic [15:0] SKIP_DAY_2100    = 16'd47541;
    localparam logic [11:0] BASE_YEAR        = 12'd1968;

    localparam logic [8:0]  YEAR1_START      = 9'd366;
    localparam logic [9:0]  YEAR2_START      = 10'd731;
    localparam logic [10:0] YEAR3_START      = 11'd1096;

    // zero-based day of year on which a month begins
    function automatic doy_t month_start(input month_idx_t idx, input logic leap);
        doy_t base;
        begin
            case (idx)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd31;
                4'd2:    base = 9'd59;
                4'd3:    base = 9'd90;
                4'd4:    base = 9'd120;
                4'd5:    base = 9'd151;
                4'd6:    base = 9'd181;
                4'd7:    base = 9'd212;
                4'd8:    base = 9'd243;
                4'd9:    base = 9'd273;
                4'd10:   base = 9'd304;
                4'd11:   base = 9'd334;
                default: base = 9'd0;
            endcase
            if (leap && idx >= 4'd2) begin
                base = base + 9'd1;
            end
            return base;
        end
    endfunction

endpackage

// ----- rtl/epoch_seconds_to_calendar.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// converts seconds since 1970-01-01 00:00:00 to gregorian date and time of day
//
//   channel | dir | tdata fields (lsb first)
//   s_      | in  | epoch_seconds[31:0]
//   m_      | out | year[11:0] month[15:12] day_of_month[20:16] hour[25:21]
//           |     | minute[31:26] second[37:32], zero fill[39:38]
//
// eight register stages, one transfer per cycle unless m_tready holds back a waiting result
// depth set by the chain of reciprocal multiplies (day, hour, minute, leap cycle)
// m_tready low with a result waiting freezes every stage together
// reset clears the stage valid bits only
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_macros.svh"

module epoch_seconds_to_calendar (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // epoch_seconds[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // year, month, day_of_month, hour, minute, second
);
    import esc_pkg::*;

    logic                  adv;
    logic [NUM_STAGES-1:0] valid_reg;

    // stage 1
    logic [31:0] t1_reg;
    logic [50:0] p1_reg, p1_next;
    // stage 2
    logic [15:0] days2_reg, days2_next;
    logic [16:0] tod2_reg, tod2_next;
    logic [31:0] tod_full;
    // stage 3
    logic [15:0] dsh3_reg, dsh3_next;
    logic [16:0] tod3_reg;
    logic [4:0]  hour3_reg, hour3_next;
    logic [26:0] prod_h;
    // stage 4
    logic [5:0]  quad4_reg, quad4_next;
    logic [15:0] dsh4_reg;
    logic [11:0] remh4_reg, remh4_next;
    logic [4:0]  hour4_reg;
    logic [32:0] prod_q;
    logic [16:0] rem_h;
    // stage 5
    logic [5:0]  quad5_reg;
    logic [10:0] dq5_reg, dq5_next;
    logic [5:0]  minute5_reg, minute5_next;
    logic [11:0] remh5_reg;
    logic [4:0]  hour5_reg;
    logic [15:0] dq_full;
    logic [20:0] prod_m;
    // stage 6
    logic [11:0] year6_reg, year6_next;
    logic        leap6_reg, leap6_next;
    doy_t        doy6_reg, doy6_next;
    logic [5:0]  second6_reg, second6_next;
    logic [5:0]  minute6_reg;
    logic [4:0]  hour6_reg;
    logic [1:0]  yi;
    logic [11:0] sec_full;
    // stage 7
    month_idx_t  mon7_reg, mon7_next;
    doy_t        doy7_reg;
    logic        leap7_reg;
    logic [11:0] year7_reg;
    logic [4:0]  hour7_reg;
    logic [5:0]  minute7_reg, second7_reg;
    // stage 8
    logic [11:0] year8_reg;
    logic [3:0]  month8_reg, month8_next;
    logic [4:0]  day8_reg, day8_next;
    logic [4:0]  hour8_reg;
    logic [5:0]  minute8_reg, second8_reg;
    doy_t        dom_full;

    assign adv      = !valid_reg[NUM_STAGES-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = {2'b00, second8_reg, minute8_reg, hour8_reg,
                       day8_reg, month8_reg, year8_reg};

    always_comb begin
        // whole days by reciprocal of 86400 / 128
        p1_next    = 51'(s_tdata[31:7]) * 51'(DAY_RECIP);

        days2_next = p1_reg[50:35];
        tod_full   = t1_reg - (32'(days2_next) * 32'(SECS_PER_DAY));
        tod2_next  = tod_full[16:0];

        dsh3_next  = days2_reg + EPOCH_DAY_OFFSET +
                     {15'd0, (days2_reg >= SKIP_DAY_2100)};
        prod_h     = 27'(tod2_reg[16:4]) * 27'(HOUR_RECIP);
        hour3_next = prod_h[25:21];

        prod_q     = 33'(dsh3_reg) * 33'(QUAD_RECIP);
        quad4_next = prod_q[32:27];
        rem_h      = tod3_reg - (17'(hour3_reg) * 17'(SECS_PER_HOUR));
        remh4_next = rem_h[11:0];

        dq_full      = dsh4_reg - (16'(quad4_reg) * 16'(DAYS_PER_QUAD));
        dq5_next     = dq_full[10:0];
        prod_m       = 21'(remh4_reg[11:2]) * 21'(MIN_RECIP);
        minute5_next = prod_m[19:14];

        if (dq5_reg < 11'(YEAR1_START)) begin
            yi        = 2'd0;
            doy6_next = dq5_reg[8:0];
        end else if (dq5_reg < 11'(YEAR2_START)) begin
            yi        = 2'd1;
            doy6_next = 9'(dq5_reg - 11'(YEAR1_START));
        end else if (dq5_reg < YEAR3_START) begin
            yi        = 2'd2;
            doy6_next = 9'(dq5_reg - 11'(YEAR2_START));
        end else begin
            yi        = 2'd3;
            doy6_next = 9'(dq5_reg - YEAR3_START);
        end
        year6_next   = BASE_YEAR + {4'd0, quad5_reg, 2'b00} + {10'd0, yi};
        leap6_next   = (yi == 2'd0);
        sec_full     = remh5_reg - (12'(minute5_reg) * 12'(SECS_PER_MIN));
        second6_next = sec_full[5:0];

        mon7_next = '0;
        for (int i = 1; i < 12; i++) begin
            if (doy6_reg >= month_start(4'(i), leap6_reg)) begin
                mon7_next = mon7_next + 4'd1;
            end
        end

        dom_full    = doy7_reg - month_start(mon7_reg, leap7_reg) + 9'd1;
        day8_next   = dom_full[4:0];
        month8_next = mon7_reg + 4'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[NUM_STAGES-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_reg      <= s_tdata;
            p1_reg      <= p1_next;

            days2_reg   <= days2_next;
            tod2_reg    <= tod2_next;

            dsh3_reg    <= dsh3_next;
            tod3_reg    <= tod2_reg;
            hour3_reg   <= hour3_next;

            quad4_reg   <= quad4_next;
            dsh4_reg    <= dsh3_reg;
            remh4_reg   <= remh4_next;
            hour4_reg   <= hour3_reg;

            quad5_reg   <= quad4_reg;
            dq5_reg     <= dq5_next;
            minute5_reg <= minute5_next;
            remh5_reg   <= remh4_reg;
            hour5_reg   <= hour4_reg;

            year6_reg   <= year6_next;
            leap6_reg   <= leap6_next;
            doy6_reg    <= doy6_next;
            second6_reg <= second6_next;
            minute6_reg <= minute5_reg;
            hour6_reg   <= hour5_reg;

            mon7_reg    <= mon7_next;
            doy7_reg    <= doy6_reg;
            leap7_reg   <= leap6_reg;
            year7_reg   <= year6_reg;
            hour7_reg   <= hour6_reg;
            minute7_reg <= minute6_reg;
            second7_reg <= second6_reg;

            year8_reg   <= year7_reg;
            month8_reg  <= month8_next;
            day8_reg    <= day8_next;
            hour8_reg   <= hour7_reg;
            minute8_reg <= minute7_reg;
            second8_reg <= second7_reg;
        end
    end

    `ESC_ASSERT(a_tod_range, valid_reg[1] |-> (tod2_reg < SECS_PER_DAY), "time of day overflow")
    `ESC_ASSERT(a_quad_rem, valid_reg[4] |-> (dq5_reg < DAYS_PER_QUAD), "leap cycle remainder overflow")
    `ESC_ASSERT(a_date_range, m_tvalid |-> (month8_reg >= 4'd1 && month8_reg <= 4'd12 && day8_reg >= 5'd1), "date out of range")
    `ESC_ASSERT(a_no_feb29_2100, (m_tvalid && year8_reg == 12'd2100 && month8_reg == 4'd2) |-> (day8_reg <= 5'd28), "feb 29 in 2100")

endmodule

// ----- tb/epoch_seconds_to_calendar_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_tb
// checks the seconds-to-calendar pipeline against a year/month walk predictor:
// directed leap, century and range-end dates, then random times sent in bursts
// with a randomly stalling receiver, one long receiver hold-off that backs up
// the pipeline, and a sender pause until every result has come back
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_tb;

    localparam int CLK_PERIOD     = 12;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 60;
    localparam int MAX_PRINTED    = 30;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  mday;
        logic [3:0]  month;
        logic [11:0] year;
    } calendar_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // epoch_seconds[31:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // year, month, day_of_month, hour, minute, second

    calendar_t   expected_dates[$];
    int          error_count = 0;
    int          dates_sent = 0;
    int          dates_checked = 0;
    int          stuck_cycles = 0;
    bit          rx_stalls_on = 1'b0;
    bit          long_hold_pending = 1'b0;

    epoch_seconds_to_calendar u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic calendar_t calendar_of(input logic [31:0] secs);
        calendar_t   c;
        int unsigned days;
        int unsigned tod;
        int unsigned yr;
        int unsigned mon;
        int unsigned len;
        int unsigned month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        days = secs / 86400;
        tod  = secs % 86400;
        c.hour   = 5'(tod / 3600);
        c.minute = 6'((tod % 3600) / 60);
        c.second = 6'(tod % 60);
        yr = 1970;
        len = is_leap_year(yr) ? 366 : 365;
        while (days >= len) begin
            days = days - len;
            yr = yr + 1;
            len = is_leap_year(yr) ? 366 : 365;
        end
        mon = 0;
        while (mon < 11) begin
            len = month_days[mon] + ((mon == 1 && is_leap_year(yr)) ? 1 : 0);
            if (days < len) break;
            days = days - len;
            mon = mon + 1;
        end
        c.year  = yr[11:0];
        c.month = mon[3:0] + 4'd1;
        c.mday  = days[4:0] + 5'd1;
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        if (error_count < MAX_PRINTED) begin
            $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        end
        error_count++;
    endtask

    // pop before push so a result never matches the input of the same edge
    always @(posedge aclk) begin : track_transfers
        calendar_t want;
        calendar_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = calendar_t'(m_tdata[37:0]);
            if (expected_dates.size() == 0) begin
                report_mismatch("unrequested result, year", 0, 32'(got.year));
            end else begin
                want = expected_dates.pop_front();
                dates_checked++;
                if (got.year !== want.year)
                    report_mismatch("year", 32'(want.year), 32'(got.year));
                if (got.month !== want.month)
                    report_mismatch("month", 32'(want.month), 32'(got.month));
                if (got.mday !== want.mday)
                    report_mismatch("day_of_month", 32'(want.mday), 32'(got.mday));
                if (got.hour !== want.hour)
                    report_mismatch("hour", 32'(want.hour), 32'(got.hour));
                if (got.minute !== want.minute)
                    report_mismatch("minute", 32'(want.minute), 32'(got.minute));
                if (got.second !== want.second)
                    report_mismatch("second", 32'(want.second), 32'(got.second));
                if (m_tdata[39:38] !== 2'b00)
                    report_mismatch("zero fill", 0, 32'(m_tdata[39:38]));
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            expected_dates.push_back(calendar_of(s_tdata));
            dates_sent++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: ready runs and stall runs, or one long hold-off on request
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // valid stays high on return; callers lower it only before a gap
    task automatic send_seconds(input logic [31:0] secs);
        s_tvalid <= 1'b1;
        s_tdata  <= secs;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_dates.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed_dates();
        logic [31:0] dates [$] = '{
            32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd86399, 32'd86400,
            32'd31535999, 32'd31536000, 32'd68169600, 32'd946684799,
            32'd946684800, 32'd951782399, 32'd951782400, 32'd951868800,
            32'd978307199, 32'd978307200, 32'h7FFF_FFFF, 32'h8000_0000,
            32'd4102444800, 32'd4107542399, 32'd4107542400, 32'd4134009599,
            32'd4134009600, 32'hAAAA_AAAA, 32'h5555_5555
        };
        rx_stalls_on = 1'b0;
        foreach (dates[i]) begin
            send_seconds(dates[i]);
        end
    endtask

    task automatic test_random_dates(input int count);
        int     burst_left;
        int     kind;
        longint unsigned secs;
        burst_left = 0;
        rx_stalls_on = 1'b1;
        for (int i = 0; i < count; i++) begin
            if (burst_left == 0) begin
                idle_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            kind = $urandom_range(0, 3);
            if (kind < 2) begin
                secs = $urandom;
            end else begin
                // near a day edge, or around the 2000 and 2100 february ends
                if (kind == 2) begin
                    secs = longint'($urandom_range(0, 49710)) * 86400;
                end else if ($urandom_range(0, 1) == 0) begin
                    secs = longint'($urandom_range(11000, 11070)) * 86400;
                end else begin
                    secs = longint'($urandom_range(47500, 47560)) * 86400;
                end
                case ($urandom_range(0, 3))
                    0: secs = secs;
                    1: secs = secs + 86399;
                    2: secs = secs - 1;
                    default: secs = secs + $urandom_range(0, 86399);
                endcase
            end
            send_seconds(secs[31:0]);
        end
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_output_hold_off();
        rx_stalls_on = 1'b0;
        wait_for_drain();
        long_hold_pending = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_seconds($urandom);
        end
        wait_for_drain();
    endtask

    initial begin : main_sequence
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_dates();
        test_random_dates(300);
        test_output_hold_off();
        test_random_dates(340);
        wait_for_drain();
        repeat (esc_pkg::NUM_STAGES + 4) @(posedge aclk);
        $display("converted %0d times, checked %0d dates: range ends, leap and century days,",
                 dates_sent, dates_checked);
        $display("random bursts with receiver stalls, one long hold-off and a full drain");
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
